// ===== hdl/olt_pkg.sv =====
// shared types and constants for the ordered list table
`default_nettype none
package olt_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMD_W  = 3;
  localparam int POS_W  = 4;
  localparam int KEY_W  = 64;
  localparam int AGE_W  = 16;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_ERR_FULL,
    OP_ERR_POS,
    OP_ERR_NF,
    OP_OK_ZERO,
    OP_INS_INIT,
    OP_SH_UP_RD,
    OP_SH_UP_WR,
    OP_INS_PUT,
    OP_RD_POS,
    OP_CAP,
    OP_SH_DN_RD,
    OP_SH_DN_WR,
    OP_DEL_DONE,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_HIT,
    OP_SCAN_NEXT
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   out_load;
    logic   idle;
  } olt_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             ptr_gt_pos;
    logic             ptr_p1_lt_cnt;
    logic             ptr_lt_cnt;
    logic             key_hit;
    logic             out_busy;
  } olt_stat_t;

endpackage
`default_nettype wire

// ===== hdl/olt_ctrl.sv =====
// command sequencer for the ordered list table
`default_nettype none
module olt_ctrl
  import olt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire olt_stat_t stat,
  output olt_ctl_t       ctl
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_SH_UP_CHK = 10'b00_0000_0100,
    S_SH_UP_WR  = 10'b00_0000_1000,
    S_CAPTURE   = 10'b00_0001_0000,
    S_SH_DN_CHK = 10'b00_0010_0000,
    S_SH_DN_WR  = 10'b00_0100_0000,
    S_SCAN_CHK  = 10'b00_1000_0000,
    S_SCAN_CMP  = 10'b01_0000_0000,
    S_FINISH    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath operation
  always_comb begin
    state_nxt    = state_r;
    ctl.op       = OP_NONE;
    ctl.out_load = 1'b0;
    ctl.idle     = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_APPEND: begin
            ctl.op    = stat.full ? OP_ERR_FULL : OP_APPEND;
            state_nxt = S_FINISH;
          end
          CMD_INSERT: begin
            if (stat.full) begin
              ctl.op    = OP_ERR_FULL;
              state_nxt = S_FINISH;
            end else if (stat.pos_gt_cnt) begin
              ctl.op    = OP_ERR_POS;
              state_nxt = S_FINISH;
            end else begin
              ctl.op    = OP_INS_INIT;
              state_nxt = S_SH_UP_CHK;
            end
          end
          CMD_DELETE, CMD_READ: begin
            if (stat.pos_ge_cnt) begin
              ctl.op    = OP_ERR_POS;
              state_nxt = S_FINISH;
            end else begin
              ctl.op    = OP_RD_POS;
              state_nxt = S_CAPTURE;
            end
          end
          CMD_FIND: begin
            ctl.op    = OP_SCAN_INIT;
            state_nxt = S_SCAN_CHK;
          end
          default: begin
            ctl.op    = OP_OK_ZERO;
            state_nxt = S_FINISH;
          end
        endcase
      end
      // shift entries up one slot, from the tail down to the insert point
      S_SH_UP_CHK: begin
        if (stat.ptr_gt_pos) begin
          ctl.op    = OP_SH_UP_RD;
          state_nxt = S_SH_UP_WR;
        end else begin
          ctl.op    = OP_INS_PUT;
          state_nxt = S_FINISH;
        end
      end
      S_SH_UP_WR: begin
        ctl.op    = OP_SH_UP_WR;
        state_nxt = S_SH_UP_CHK;
      end
      S_CAPTURE: begin
        ctl.op    = OP_CAP;
        state_nxt = (stat.cmd == CMD_DELETE) ? S_SH_DN_CHK : S_FINISH;
      end
      // shift entries down one slot over the removed one
      S_SH_DN_CHK: begin
        if (stat.ptr_p1_lt_cnt) begin
          ctl.op    = OP_SH_DN_RD;
          state_nxt = S_SH_DN_WR;
        end else begin
          ctl.op    = OP_DEL_DONE;
          state_nxt = S_FINISH;
        end
      end
      S_SH_DN_WR: begin
        ctl.op    = OP_SH_DN_WR;
        state_nxt = S_SH_DN_CHK;
      end
      // linear key search
      S_SCAN_CHK: begin
        if (stat.ptr_lt_cnt) begin
          ctl.op    = OP_SCAN_RD;
          state_nxt = S_SCAN_CMP;
        end else begin
          ctl.op    = OP_ERR_NF;
          state_nxt = S_FINISH;
        end
      end
      S_SCAN_CMP: begin
        if (stat.key_hit) begin
          ctl.op    = OP_SCAN_HIT;
          state_nxt = S_FINISH;
        end else begin
          ctl.op    = OP_SCAN_NEXT;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/olt_dp.sv =====
// entry storage, pointers and result registers for the ordered list table
`default_nettype none
module olt_dp
  import olt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire olt_ctl_t          ctl,
  output olt_stat_t              stat,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [KEY_W-1:0]  in_name_key,
  input  wire logic [AGE_W-1:0]  in_age_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_result_index,
  output logic [KEY_W-1:0]       out_key,
  output logic [AGE_W-1:0]       out_age,
  output logic [LEN_W-1:0]       out_list_length
);

  localparam int ENT_W = KEY_W + AGE_W;

  // entry memory: one write port, one registered read port
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENT_W-1:0] wr_data;

  // captured command
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [KEY_W-1:0] key_r;
  logic [AGE_W-1:0] age_r;

  // list length and walk pointer
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic [CNT_W-1:0] pos_ext;

  // result being built, then output register
  logic [STAT_W-1:0] res_status_r;
  logic [IDX_W-1:0]  res_index_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [AGE_W-1:0]  res_age_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [AGE_W-1:0]  out_age_r;
  logic [LEN_W-1:0]  out_len_r;

  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);
  assign pos_ext = CNT_W'(pos_r);

  // status to the controller
  assign stat.cmd           = cmd_r;
  assign stat.full          = (cnt_r >= CNT_W'(DEPTH));
  assign stat.pos_gt_cnt    = (pos_ext > cnt_r);
  assign stat.pos_ge_cnt    = (pos_ext >= cnt_r);
  assign stat.ptr_gt_pos    = (ptr_r > pos_ext);
  assign stat.ptr_p1_lt_cnt = (ptr_inc < cnt_r);
  assign stat.ptr_lt_cnt    = (ptr_r < cnt_r);
  assign stat.key_hit       = (rd_data_r[ENT_W-1:AGE_W] == key_r);
  assign stat.out_busy      = out_valid_r & out_stall;

  // memory port selection and pointer / length updates
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[ADDR_W-1:0];
    wr_data = rd_data_r;
    rd_addr = ptr_r[ADDR_W-1:0];
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    case (ctl.op)
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = {key_r, age_r};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_INS_INIT: begin
        ptr_nxt = cnt_r;
      end
      OP_SH_UP_RD: begin
        rd_addr = ptr_dec[ADDR_W-1:0];
      end
      OP_SH_UP_WR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_dec;
      end
      OP_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_ext[ADDR_W-1:0];
        wr_data = {key_r, age_r};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_RD_POS: begin
        rd_addr = pos_ext[ADDR_W-1:0];
        ptr_nxt = pos_ext;
      end
      OP_SH_DN_RD: begin
        rd_addr = ptr_inc[ADDR_W-1:0];
      end
      OP_SH_DN_WR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_inc;
      end
      OP_DEL_DONE: begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_SCAN_INIT: begin
        ptr_nxt = '0;
      end
      OP_SCAN_NEXT: begin
        ptr_nxt = ptr_inc;
      end
      default: begin
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // length and pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ptr_r <= ptr_nxt;
  end

  // command capture on input transfer
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      key_r <= in_name_key;
      age_r <= in_age_value;
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_APPEND: begin
        res_status_r <= ST_OK;
        res_index_r  <= IDX_W'(cnt_r);
        res_key_r    <= key_r;
        res_age_r    <= age_r;
      end
      OP_INS_PUT: begin
        res_status_r <= ST_OK;
        res_index_r  <= pos_r;
        res_key_r    <= key_r;
        res_age_r    <= age_r;
      end
      OP_CAP: begin
        res_status_r <= ST_OK;
        res_index_r  <= pos_r;
        res_key_r    <= rd_data_r[ENT_W-1:AGE_W];
        res_age_r    <= rd_data_r[AGE_W-1:0];
      end
      OP_SCAN_HIT: begin
        res_status_r <= ST_OK;
        res_index_r  <= IDX_W'(ptr_r);
        res_key_r    <= rd_data_r[ENT_W-1:AGE_W];
        res_age_r    <= rd_data_r[AGE_W-1:0];
      end
      OP_ERR_FULL, OP_ERR_POS, OP_ERR_NF, OP_OK_ZERO: begin
        res_status_r <= (ctl.op == OP_ERR_FULL) ? ST_FULL :
                        (ctl.op == OP_ERR_POS)  ? ST_BADPOS :
                        (ctl.op == OP_ERR_NF)   ? ST_NOTFOUND : ST_OK;
        res_index_r  <= '0;
        res_key_r    <= '0;
        res_age_r    <= '0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_key_r    <= res_key_r;
      out_age_r    <= res_age_r;
      out_len_r    <= LEN_W'(cnt_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_key          = out_key_r;
  assign out_age          = out_age_r;
  assign out_list_length  = out_len_r;

endmodule
`default_nettype wire

// ===== hdl/ordered_list_table_top.sv =====
// top level of the ordered list table
// Ordered list of up to DEPTH (16) key/age entries held in a memory with one
// write port and one registered read port. One command is taken at a time:
// in_stall is low only while the sequencer is idle, and the result sits in an
// output register so a new command can be taken while it waits. Insert and
// delete move entries one at a time through the memory, and find reads them
// one at a time from index 0 until the first hit; a finished result waits
// while the previous result is held by out_stall.
// Entries are undefined after reset; only the length register, the output
// valid flag and the sequencer state are cleared.
`default_nettype none
module ordered_list_table_top
  import olt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [KEY_W-1:0]  in_name_key,
  input  wire logic [AGE_W-1:0]  in_age_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_result_index,
  output logic [KEY_W-1:0]       out_key,
  output logic [AGE_W-1:0]       out_age,
  output logic [LEN_W-1:0]       out_list_length
);

  olt_ctl_t  ctl;
  olt_stat_t stat;

  // input transfer only while the sequencer is idle
  assign in_stall = ~ctl.idle;

  olt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  olt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_name_key      (in_name_key),
    .in_age_value     (in_age_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_key          (out_key),
    .out_age          (out_age),
    .out_list_length  (out_list_length)
  );

endmodule
`default_nettype wire

// ===== bench/tb_ordered_list_table_top.sv =====
// testbench for the ordered list table: directed edge cases and random command traffic
`timescale 1ns / 100ps
module tb_ordered_list_table_top
  import olt_pkg::*;
();

  localparam int CLK_HALF = 10;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 12;
  localparam int DRAIN_LIMIT = 4000;
  localparam logic [KEY_W-1:0] DUP_KEY = 64'h4A4F_484E_0000_0000;
  localparam logic [KEY_W-1:0] ABSENT_KEY = 64'h0123_4567_89AB_CDEF;

  // one result transfer, field by field
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [LEN_W-1:0]  length;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [KEY_W-1:0]  in_name_key = '0;
  logic [AGE_W-1:0]  in_age_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_result_index;
  logic [KEY_W-1:0]  out_key;
  logic [AGE_W-1:0]  out_age;
  logic [LEN_W-1:0]  out_list_length;

  // shadow copy of the list contents
  logic [KEY_W-1:0] list_keys [DEPTH];
  logic [AGE_W-1:0] list_ages [DEPTH];
  int               list_count = 0;

  table_result_t pending_results [$];
  table_result_t oldest_result;
  int            error_count = 0;
  int            idle_pct = 19;

  logic [KEY_W-1:0] key_pool [6] = '{64'h0, '1, DUP_KEY, 64'h0000_0000_0000_0001,
                                     64'h8000_0000_0000_0000, 64'h5A5A_A5A5_5A5A_A5A5};

  ordered_list_table_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_name_key      (in_name_key),
    .in_age_value     (in_age_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_key          (out_key),
    .out_age          (out_age),
    .out_list_length  (out_list_length)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // applies one command to the shadow list and returns the result it should give
  function automatic table_result_t table_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [POS_W-1:0] pos,
                                                input logic [KEY_W-1:0] key,
                                                input logic [AGE_W-1:0] age);
    table_result_t r;
    int            i;
    bit            hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_keys[list_count] = key;
          list_ages[list_count] = age;
          r.index = IDX_W'(list_count);
          r.key = key;
          r.age = age;
          list_count++;
        end
      end
      CMD_INSERT: begin
        // full is tested before the position
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_count; i > int'(pos); i--) begin
            list_keys[i] = list_keys[i-1];
            list_ages[i] = list_ages[i-1];
          end
          list_keys[pos] = key;
          list_ages[pos] = age;
          r.index = pos;
          r.key = key;
          r.age = age;
          list_count++;
        end
      end
      CMD_DELETE: begin
        if (int'(pos) >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.index = pos;
          r.key = list_keys[pos];
          r.age = list_ages[pos];
          for (i = int'(pos) + 1; i < list_count; i++) begin
            list_keys[i-1] = list_keys[i];
            list_ages[i-1] = list_ages[i];
          end
          list_count--;
        end
      end
      CMD_READ: begin
        if (int'(pos) >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.index = pos;
          r.key = list_keys[pos];
          r.age = list_ages[pos];
        end
      end
      CMD_FIND: begin
        // first matching entry wins
        for (i = 0; i < list_count && !hit; i++) begin
          if (list_keys[i] == key) begin
            hit = 1'b1;
            r.index = IDX_W'(i);
            r.key = list_keys[i];
            r.age = list_ages[i];
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
    r.length = LEN_W'(list_count);
    return r;
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [KEY_W-1:0] key, input logic [AGE_W-1:0] age);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_name_key <= key;
    in_age_value <= age;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(table_apply(cmd, pos, key, age));
    @(negedge clk);
  endtask

  // sender holds off until every expected result is back
  task automatic wait_for_results();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // errors on an empty list, the unused command codes and a first insert at slot 0
  task automatic test_empty_table();
    send_item(CMD_READ, 4'd15, '0, '0);
    send_item(CMD_DELETE, 4'd0, '0, '0);
    send_item(CMD_FIND, 4'd0, ABSENT_KEY, '0);
    send_item(CMD_W'(5), 4'd9, '1, '1);
    send_item(CMD_W'(7), 4'd15, DUP_KEY, 16'h1234);
    send_item(CMD_INSERT, 4'd1, DUP_KEY, 16'h0001);
    send_item(CMD_INSERT, 4'd0, 64'h0, 16'h0000);
  endtask

  // append up to capacity with extreme and repeated keys
  task automatic test_fill_to_capacity();
    int               i;
    logic [KEY_W-1:0] key;
    for (i = 1; i < DEPTH; i++) begin
      case (i)
        1:       key = '1;
        2, 9:    key = DUP_KEY;
        5:       key = 64'h8000_0000_0000_0001;
        default: key = {$urandom, $urandom};
      endcase
      send_item(CMD_APPEND, POS_W'(i), key, (i == 1) ? 16'hFFFF : AGE_W'($urandom_range(0, 65535)));
    end
  endtask

  // full list, last slot, duplicate keys, insert at the end
  task automatic test_full_list_edges();
    send_item(CMD_APPEND, 4'd0, ABSENT_KEY, 16'hBEEF);
    send_item(CMD_INSERT, 4'd15, ABSENT_KEY, 16'hBEEF);
    send_item(CMD_READ, 4'd15, '0, '0);
    send_item(CMD_FIND, 4'd0, DUP_KEY, '0);
    send_item(CMD_FIND, 4'd0, '1, '0);
    send_item(CMD_FIND, 4'd0, ABSENT_KEY, '0);
    send_item(CMD_DELETE, 4'd15, '0, '0);
    send_item(CMD_INSERT, 4'd15, 64'hFFFF_0000_FFFF_0000, 16'h8000);
    send_item(CMD_DELETE, 4'd0, '0, '0);
    send_item(CMD_READ, 4'd0, '0, '0);
  endtask

  // random commands; grow_pct weights append and insert against the rest
  task automatic test_random_traffic(input int n_items, input int grow_pct);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    int               roll;
    int               hi;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = CMD_W'($urandom_range(5, 7));
      end else if (roll < 3 + grow_pct / 2) begin
        cmd = CMD_APPEND;
      end else if (roll < 3 + grow_pct) begin
        cmd = CMD_INSERT;
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_DELETE;
          1:       cmd = CMD_READ;
          default: cmd = CMD_FIND;
        endcase
      end
      // mostly a legal slot, sometimes any position
      hi = (cmd == CMD_INSERT) ? list_count : list_count - 1;
      if (hi > 15) hi = 15;
      if (hi >= 0 && $urandom_range(0, 99) < 80) pos = POS_W'($urandom_range(0, hi));
      else pos = POS_W'($urandom_range(0, 15));
      // keys already in the list make finds hit
      roll = $urandom_range(0, 99);
      if (roll < 40 && list_count > 0) key = list_keys[$urandom_range(0, list_count - 1)];
      else if (roll < 65) key = key_pool[$urandom_range(0, 5)];
      else key = {$urandom, $urandom};
      send_item(cmd, pos, key, AGE_W'($urandom_range(0, 65535)));
    end
  endtask

  // long stretch with both sides always ready
  task automatic test_back_to_back(input int n_items);
    idle_pct = 0;
    test_random_traffic(n_items, 48);
    idle_pct = 19;
  endtask

  // result side backpressure
  always @(negedge clk) begin
    out_stall <= (idle_pct > 0) && ($urandom_range(0, 99) < idle_pct);
  end

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0h index %0h",
                 $time, out_status, out_result_index);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status)
          report_mismatch("status", KEY_W'(oldest_result.status), KEY_W'(out_status));
        if (out_result_index !== oldest_result.index)
          report_mismatch("result_index", KEY_W'(oldest_result.index), KEY_W'(out_result_index));
        if (out_key !== oldest_result.key)
          report_mismatch("key", oldest_result.key, out_key);
        if (out_age !== oldest_result.age)
          report_mismatch("age", KEY_W'(oldest_result.age), KEY_W'(out_age));
        if (out_list_length !== oldest_result.length)
          report_mismatch("list_length", KEY_W'(oldest_result.length), KEY_W'(out_list_length));
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_ordered_list_table_top failed");
    $finish;
  end

  // test sequence
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_to_capacity();
    test_full_list_edges();
    test_random_traffic(160, 75);
    wait_for_results();
    test_random_traffic(160, 20);
    test_back_to_back(120);
    test_random_traffic(260, 48);
    wait_for_results();
    if (error_count == 0) $display("tb_ordered_list_table_top passed");
    else $display("tb_ordered_list_table_top failed");
    $finish;
  end

endmodule
